// ===== src/tbtc_pkg.sv =====
// Shared constants and types for the tempo beat transport clock.
// No dependencies; used by the divider and the top level.
`default_nettype none
package tbtc_pkg;
   localparam int unsigned POS_W = 32;
   localparam int unsigned TIME_W = 48;
   localparam int unsigned BEAT_W = 17;
   localparam int unsigned POS_FRAC = 16;
   localparam int unsigned TEMPO_W = 16;
   localparam int unsigned NUM_W = 46;
   localparam int unsigned DEN_W = 16;
   localparam int unsigned DT_W = 30;
   localparam int unsigned MAX_ITERATIONS_DEF = 32;
   localparam logic [TEMPO_W-1:0] TEMPO_RESET = 16'd7680;
   localparam logic [DEN_W-1:0] SEC_PER_MIN_Q6 = 16'd3840;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [0:0] CSR_TEMPO = 1'b0;
   localparam logic [0:0] CSR_PLAYING = 1'b1;
   localparam logic KIND_BEAT = 1'b0;
   localparam logic KIND_SEGMENT = 1'b1;
   localparam logic MODE_ADVANCE = 1'b0;
   localparam logic MODE_LOCATE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [POS_W-1:0]  start_position;
      logic [POS_W-1:0]  end_position;
      logic [TIME_W-1:0] event_time;
   } result_type;
endpackage
`default_nettype wire

// ===== src/tbtc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tbtc_pkg for the operand widths.
`default_nettype none
module tbtc_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tbtc_pkg::NUM_W-1:0] num,
   input  wire logic [tbtc_pkg::DEN_W-1:0] den,
   output logic                            done,
   output logic [tbtc_pkg::NUM_W-1:0]      quo
);
   import tbtc_pkg::*;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      fits = rem_sh >= {1'b0, den_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;
endmodule
`default_nettype wire

// ===== src/tempo_beat_transport_clock.sv =====
// Top level of the musical transport clock: state, sequencer and result queue.
// Depends on tbtc_pkg and instantiates tbtc_div.
//
// Use: a request on req_ carries a mode in req_tuser (advance or locate), a
// time and a beat position. Locate sets the position and time and gives no
// result. Advance moves the clock to the requested time; while playing with a
// nonzero tempo it gives a beat result for each whole beat crossed and one
// segment result per step, the final one marked by rsp_tlast.
// Timing: beat-time recomputations and position steps share one bit-serial
// divider. A locate or a configuration write that recomputes keeps req_tready
// low until the recomputation is done. An advance iteration ends on the next
// beat, or needs a position step or a beat-time recomputation, or both; an
// advance runs at most MAX_ITERATIONS segment steps, marking its last result
// truncated if it stops short; a stopped advance only moves the clock forward.
// Results leave through an output register backed by one pending result, so
// a stalled receiver holds the sequencer at its next result without loss.
// After reset the tempo is 120 beats per minute, the transport is stopped and
// the position, clock time and next beat time are zero; req_tready is low while busy.
`default_nettype none
module tempo_beat_transport_clock #(
   parameter int unsigned MAX_ITERATIONS = tbtc_pkg::MAX_ITERATIONS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [79:0]   req_tdata,  // time_req[47:0], position[79:48]
   input  wire logic          req_tuser,  // mode
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [119:0]       rsp_tdata,  // start[31:0], end[63:32], time[111:64], truncated[112]
   output logic               rsp_tuser,  // kind
   output logic               rsp_tlast,
   input  wire logic          csr_we,
   input  wire logic [0:0]    csr_index,
   input  wire logic [15:0]   csr_wdata
);
   import tbtc_pkg::*;
   localparam int unsigned IT_W = $clog2(MAX_ITERATIONS + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_ITER  = 10'b0000000010,
      S_RCA   = 10'b0000000100,
      S_RCD   = 10'b0000001000,
      S_SEG   = 10'b0000010000,
      S_PDM   = 10'b0000100000,
      S_PDD   = 10'b0001000000,
      S_PUSH  = 10'b0010000000,
      S_FLUSH = 10'b0100000000,
      S_STOP  = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [TEMPO_W-1:0] tempo_ff, tempo_in;
   logic              playing_ff, playing_in;
   logic [POS_W-1:0]  pos_ff, pos_in, begin_ff, begin_in;
   logic [TIME_W-1:0] clk_ff, clk_in, nbt_ff, nbt_in, target_ff, target_in;
   logic [BEAT_W-1:0] nwb_ff, nwb_in;
   logic [IT_W-1:0]   it_ff, it_in;
   logic              rc_to_seg_ff, rc_to_seg_in, push_to_rc_ff, push_to_rc_in;
   result_type        new_ff, new_in, pend_ff, pend_in, out_ff, out_in;
   logic              pend_vld_ff, pend_vld_in, out_vld_ff, out_vld_in;
   logic              out_last_ff, out_last_in, out_trunc_ff, out_trunc_in;
   logic [NUM_W-1:0]  prod_ff, prod_in;

   logic              div_start, div_done;
   logic [NUM_W-1:0]  div_num, div_quo;
   logic [DEN_W-1:0]  div_den;
   logic [32:0]       units, dp;
   logic [TIME_W-1:0] dt;
   logic [DT_W-1:0]   dt_cap;
   logic [TIME_W:0]   t_sum;
   logic [35:0]       np;
   logic              out_free, cfg_rc;

   tbtc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      units = {nwb_ff, 16'b0};
      dp = (units > {1'b0, pos_ff}) ? units - {1'b0, pos_ff} : '0;
      dt = target_ff - clk_ff;
      dt_cap = (dt > TIME_W'(1 << (POS_FRAC + 13))) ? DT_W'(1 << (POS_FRAC + 13)) : dt[DT_W-1:0];
      t_sum = {1'b0, clk_ff} + {3'b0, div_quo};
      np = {4'b0, pos_ff} + {1'b0, div_quo[34:0]};
      if (np > {3'b0, units}) np = {3'b0, units};
      if (np > 36'hFFFFFFFF) np = 36'hFFFFFFFF;
      out_free = !out_vld_ff || rsp_tready;

      state_in = state_ff;
      tempo_in = tempo_ff;
      playing_in = playing_ff;
      pos_in = pos_ff;
      begin_in = begin_ff;
      clk_in = clk_ff;
      nbt_in = nbt_ff;
      target_in = target_ff;
      nwb_in = nwb_ff;
      it_in = it_ff;
      rc_to_seg_in = rc_to_seg_ff;
      push_to_rc_in = push_to_rc_ff;
      new_in = new_ff;
      pend_in = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      out_last_in = out_last_ff;
      out_trunc_in = out_trunc_ff;
      prod_in = prod_ff;
      div_start = 1'b0;
      div_num = ({13'b0, dp} << 12) - ({13'b0, dp} << 8);
      div_den = tempo_ff;
      cfg_rc = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               target_in = req_tdata[47:0];
               if (req_tuser == MODE_LOCATE) begin
                  if (req_tdata[79:48] != pos_ff) begin
                     pos_in = req_tdata[79:48];
                     nwb_in = BEAT_W'(({1'b0, req_tdata[79:48]} + 33'hFFFF) >> POS_FRAC);
                     cfg_rc = 1'b1;
                  end
                  if (req_tdata[47:0] != clk_ff) begin
                     clk_in = req_tdata[47:0];
                     cfg_rc = 1'b1;
                  end
               end else if (!playing_ff || tempo_ff == '0) begin
                  state_in = S_STOP;
               end else begin
                  it_in = '0;
                  state_in = S_ITER;
               end
            end
         end
         S_STOP: begin
            if (clk_ff < target_ff) clk_in = target_ff;
            state_in = S_IDLE;
         end
         S_ITER: begin
            if (it_ff == IT_W'(MAX_ITERATIONS) || !(clk_ff < target_ff)) begin
               state_in = S_FLUSH;
            end else if ({1'b0, pos_ff} == units) begin
               new_in = '{KIND_BEAT, pos_ff, pos_ff, clk_ff};
               nwb_in = nwb_ff + 1'b1;
               push_to_rc_in = 1'b1;
               state_in = S_PUSH;
            end else begin
               state_in = S_SEG;
            end
         end
         S_RCA: begin
            if (tempo_ff == '0) begin
               nbt_in = TIME_MAX;
               state_in = rc_to_seg_ff ? S_SEG : S_IDLE;
            end else begin
               div_start = 1'b1;
               state_in = S_RCD;
            end
         end
         S_RCD: begin
            if (div_done) begin
               nbt_in = t_sum[TIME_W] ? TIME_MAX : t_sum[TIME_W-1:0];
               state_in = rc_to_seg_ff ? S_SEG : S_IDLE;
            end
         end
         S_SEG: begin
            begin_in = pos_ff;
            if (nbt_ff < target_ff && units <= 33'hFFFFFFFF) begin
               pos_in = units[POS_W-1:0];
               clk_in = nbt_ff;
               new_in = '{KIND_SEGMENT, pos_ff, units[POS_W-1:0], nbt_ff};
               it_in = it_ff + 1'b1;
               push_to_rc_in = 1'b0;
               state_in = S_PUSH;
            end else begin
               prod_in = {30'b0, tempo_ff} * {16'b0, dt_cap};
               state_in = S_PDM;
            end
         end
         S_PDM: begin
            div_num = prod_ff;
            div_den = SEC_PER_MIN_Q6;
            div_start = 1'b1;
            state_in = S_PDD;
         end
         S_PDD: begin
            if (div_done) begin
               pos_in = np[POS_W-1:0];
               clk_in = target_ff;
               new_in = '{KIND_SEGMENT, begin_ff, np[POS_W-1:0], target_ff};
               it_in = it_ff + 1'b1;
               push_to_rc_in = 1'b0;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  out_in = pend_ff;
                  out_vld_in = 1'b1;
                  out_last_in = 1'b0;
                  out_trunc_in = 1'b0;
               end
               pend_in = new_ff;
               pend_vld_in = 1'b1;
               if (push_to_rc_ff) begin
                  rc_to_seg_in = 1'b1;
                  state_in = S_RCA;
               end else begin
                  state_in = S_ITER;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_in = pend_ff;
               out_vld_in = 1'b1;
               out_last_in = 1'b1;
               out_trunc_in = clk_ff < target_ff;
               pend_vld_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_TEMPO: begin
               if (csr_wdata != tempo_ff) begin
                  tempo_in = csr_wdata;
                  cfg_rc = 1'b1;
               end
            end
            CSR_PLAYING: begin
               playing_in = csr_wdata[0];
               if (csr_wdata[0]) cfg_rc = 1'b1;
            end
            default: ;
         endcase
      end
      if (cfg_rc) begin
         rc_to_seg_in = 1'b0;
         state_in = S_RCA;
      end
   end

   always_ff @(posedge clock) begin
      begin_ff <= begin_in;
      target_ff <= target_in;
      new_ff <= new_in;
      pend_ff <= pend_in;
      out_ff <= out_in;
      out_last_ff <= out_last_in;
      out_trunc_ff <= out_trunc_in;
      prod_ff <= prod_in;
      push_to_rc_ff <= push_to_rc_in;
      rc_to_seg_ff <= rc_to_seg_in;
      it_ff <= it_in;
      if (reset) begin
         state_ff <= S_IDLE;
         tempo_ff <= TEMPO_RESET;
         playing_ff <= 1'b0;
         pos_ff <= '0;
         clk_ff <= '0;
         nbt_ff <= '0;
         nwb_ff <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tempo_ff <= tempo_in;
         playing_ff <= playing_in;
         pos_ff <= pos_in;
         clk_ff <= clk_in;
         nbt_ff <= nbt_in;
         nwb_ff <= nwb_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser = out_ff.kind;
   assign rsp_tlast = out_last_ff;
   assign rsp_tdata = {7'b0, out_trunc_ff, out_ff.event_time, out_ff.end_position,
                       out_ff.start_position};
endmodule
`default_nettype wire
